// ===== rtl/gau_pkg.sv =====
// Shared constants and tables for the GELU activation datapath.
package gau_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS   = 12;   // Q.12 samples
    localparam int XC_W        = 16;   // clamped sample used for z
    localparam int SQ_W        = 20;   // x^2 in Q.12
    localparam int CU_W        = 24;   // x^3 in Q.12
    localparam int U_W         = 20;   // x + 0.044715*x^3
    localparam int Z_W         = 22;   // z in Q.12
    localparam int Q30_W       = 30;   // fraction and series terms in Q.30
    localparam int EXP_N_W     = 4;    // integer part of |z| below the limit

    // Clamp limits for the cubic path
    localparam logic signed [XC_W-1:0] XC_MAX = 16'sh7fff;
    localparam logic signed [XC_W-1:0] XC_MIN = 16'sh8000;

    // Polynomial and scale coefficients
    localparam logic signed [13:0] C_CUBE_Q16  = 14'sd2930;   // 0.044715
    localparam int                 CUBE_SHIFT  = 16;
    localparam logic signed [15:0] C_SCALE_Q14 = 16'sd26145;  // 1.5957691
    localparam int                 SCALE_SHIFT = 14;

    // Exponential constants
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [28:0] EXP_M1_Q30 = 29'd395007542;       // exp(-1)

    // Pipeline step counts
    localparam int TAYLOR_TERMS = 10;
    localparam int EXP_STEPS    = 15;
    localparam int DIV_STEPS    = 31;

    // floor(2^31 / k) for the series divisors k = 1 .. TAYLOR_TERMS
    localparam logic [31:0] RECIP_Q31 [TAYLOR_TERMS] = '{
        32'd2147483648,
        32'd1073741824,
        32'd715827882,
        32'd536870912,
        32'd429496729,
        32'd357913941,
        32'd306783378,
        32'd268435456,
        32'd238609294,
        32'd214748364
    };

endpackage

// ===== rtl/gau_if.sv =====
// Valid/ready stream interfaces for the sample and result channels.
interface gau_x_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] x_in;

    modport source (output valid, output x_in, input ready);
    modport sink   (input valid, input x_in, output ready);
endinterface

interface gau_y_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] y_out;

    modport source (output valid, output y_out, input ready);
    modport sink   (input valid, input y_out, output ready);
endinterface

// ===== rtl/gelu_activation_unit_core.sv =====
// GELU activation (sigmoid form of the tanh approximation), deep pipeline top level.
//
// Usage:
//   sample : valid/ready sink, one signed Q.12 x_in per beat.
//   result : valid/ready source, one signed Q.12 y_out per beat, in sample order.
//   A beat moves on a rising clk edge with valid and ready both high.
// Throughput: one sample per cycle while the skid is empty. The path runs through cubic
//   and scale multipliers, ten Taylor terms (three stages each: product,
//   reciprocal multiply, remainder correction), fifteen exp(-1) multiply
//   steps and a 31-stage restoring divider for the sigmoid, then the final
//   multiply; every stage holds one sample.
// Stall: an output register plus a one-beat skid register sit after the
//   pipeline. When result.ready is low and the output register is full, the
//   pipeline still delivers its head into the skid; while the skid is full the
//   whole pipeline holds and sample.ready is low. Nothing is dropped or repeated.
// Reset: rst_n (asynchronous, active low) clears all valid bits; data
//   registers are not reset. The block keeps no state between samples.
module gelu_activation_unit_core #(
    parameter int DATA_WIDTH = 16
) (
    input logic     clk,
    input logic     rst_n,
    gau_x_if.sink   sample,
    gau_y_if.source result
);

    localparam int T  = gau_pkg::TAYLOR_TERMS;
    localparam int E  = gau_pkg::EXP_STEPS;
    localparam int DV = gau_pkg::DIV_STEPS;
    localparam int XW = gau_pkg::XC_W;
    localparam int QW = gau_pkg::Q30_W;
    localparam int NW = gau_pkg::EXP_N_W;
    localparam int FB = gau_pkg::FRAC_BITS;

    // Stage map
    localparam int ST_IN   = 0;
    localparam int ST_SQ   = 1;
    localparam int ST_CU   = 2;
    localparam int ST_U    = 3;
    localparam int ST_Z    = 4;
    localparam int ST_DEC  = 5;
    localparam int ST_TAY  = 6;
    localparam int ST_ACC  = ST_TAY + 3 * T;
    localparam int ST_EXP  = ST_ACC + 1;
    localparam int ST_DIVD = ST_EXP + E;
    localparam int ST_DIV  = ST_DIVD + 1;
    localparam int ST_SEL  = ST_DIV + DV;
    localparam int ST_MUL  = ST_SEL + 1;
    localparam int NUM_ST  = ST_MUL + 1;

    localparam int P_W = DATA_WIDTH + 32;
    localparam int Y_W = DATA_WIDTH + 2;

    localparam logic signed [P_W-1:0] ROUND_HALF = P_W'(longint'(1) << 29);
    localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((longint'(1) << (DATA_WIDTH - 1)) - 1);
    localparam logic signed [Y_W-1:0] Y_MIN = Y_W'(-(longint'(1) << (DATA_WIDTH - 1)));
    localparam int GELU_FLOOR_Q12 = -1024;

    localparam bit LAST_SUB = (T % 2) == 1;

    // Per-sample side data that travels with the valid bit
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x;
        logic                         zneg;
        logic                         big;
        logic [NW-1:0]                n;
    } side_t;

    logic              adv;
    logic [NUM_ST-1:0] valid_reg;
    side_t             side_reg  [NUM_ST];
    side_t             side_next [NUM_ST];

    // Cubic and scale stages
    logic signed [31:0]            x_wide;
    logic signed [XW-1:0]          xc_next;
    logic signed [XW-1:0]          xc0_reg, xc1_reg, xc2_reg;
    logic signed [2*XW-1:0]        sq_prod;
    logic signed [gau_pkg::SQ_W-1:0] sq_next, sq_reg;
    logic signed [gau_pkg::SQ_W+XW-1:0] cu_prod;
    logic signed [gau_pkg::CU_W-1:0] cu_next, cu_reg;
    logic signed [gau_pkg::CU_W+13:0] t_prod;
    logic signed [gau_pkg::U_W-1:0] u_next, u_reg;
    logic signed [gau_pkg::U_W+15:0] z_prod;
    logic signed [gau_pkg::Z_W-1:0] z_next, z_reg;

    // Decode of |z|
    logic                          dec_zneg;
    logic [gau_pkg::Z_W-1:0]       a_mag;
    logic [QW-1:0]                 dec_f30_next, dec_f30_reg;

    // Taylor series stages
    logic [QW-1:0]        ta_q_next   [T], ta_q_reg   [T];
    logic signed [31:0]   ta_sum_next [T], ta_sum_reg [T];
    logic [QW-1:0]        ta_f30_next [T], ta_f30_reg [T];
    logic [QW-1:0]        tb_q_next   [T], tb_q_reg   [T];
    logic [QW-1:0]        tb_qh_next  [T], tb_qh_reg  [T];
    logic signed [31:0]   tb_sum_next [T], tb_sum_reg [T];
    logic [QW-1:0]        tb_f30_next [T], tb_f30_reg [T];
    logic [30:0]          tc_term_next [T], tc_term_reg [T];
    logic signed [31:0]   tc_sum_next  [T], tc_sum_reg  [T];
    logic [QW-1:0]        tc_f30_next  [T], tc_f30_reg  [T];

    logic signed [31:0]   sum_fin;
    logic [30:0]          acc_next, acc_reg;

    // exp(-1) multiply steps
    logic [30:0]          ex_next [E], ex_reg [E];

    // Sigmoid divider
    logic [30:0]          e_sel;
    logic [31:0]          divd_next, divd_reg;
    logic [31:0]          dv_r_next [DV], dv_r_reg [DV];
    logic [31:0]          dv_d_next [DV], dv_d_reg [DV];
    logic [30:0]          dv_q_next [DV], dv_q_reg [DV];

    // Select, multiply, round
    logic [30:0]          sel_s_next, sel_s_reg;
    logic signed [P_W-1:0] mul_p_next, mul_p_reg;
    logic signed [P_W-1:0] y_rnd;
    logic signed [Y_W-1:0] y_wide;
    logic signed [DATA_WIDTH-1:0] y_sat;

    // Output register and skid
    logic                         out_valid_reg, out_valid_next;
    logic signed [DATA_WIDTH-1:0] out_y_reg, out_y_next;
    logic                         skid_valid_reg, skid_valid_next;
    logic signed [DATA_WIDTH-1:0] skid_y_reg, skid_y_next;

    // Advance the whole pipeline unless the skid holds a beat
    assign adv          = !skid_valid_reg;
    assign sample.ready = adv;
    assign result.valid = out_valid_reg;
    assign result.y_out = out_y_reg;

    // Clamp the sample for the cubic path
    always_comb begin
        x_wide = 32'(sample.x_in);
        if (x_wide > 32'(gau_pkg::XC_MAX)) begin
            xc_next = gau_pkg::XC_MAX;
        end else if (x_wide < 32'(gau_pkg::XC_MIN)) begin
            xc_next = gau_pkg::XC_MIN;
        end else begin
            xc_next = XW'(x_wide);
        end
    end

    // Square, cube, polynomial and scale
    always_comb begin
        sq_prod = xc0_reg * xc0_reg;
        sq_next = gau_pkg::SQ_W'(sq_prod >>> FB);
        cu_prod = sq_reg * xc1_reg;
        cu_next = gau_pkg::CU_W'(cu_prod >>> FB);
        t_prod  = cu_reg * gau_pkg::C_CUBE_Q16;
        u_next  = gau_pkg::U_W'(t_prod >>> gau_pkg::CUBE_SHIFT) + gau_pkg::U_W'(xc2_reg);
        z_prod  = u_reg * gau_pkg::C_SCALE_Q14;
        z_next  = gau_pkg::Z_W'(z_prod >>> gau_pkg::SCALE_SHIFT);
    end

    // Split |z| into integer and fraction parts
    always_comb begin
        dec_zneg     = z_reg[gau_pkg::Z_W-1];
        a_mag        = dec_zneg ? -z_reg : z_reg;
        dec_f30_next = {a_mag[FB-1:0], {(QW - FB){1'b0}}};
    end

    // Side data: load at entry, fill in the sign and exponent fields at decode
    always_comb begin
        side_next[0].x    = sample.x_in;
        side_next[0].zneg = 1'b0;
        side_next[0].big  = 1'b0;
        side_next[0].n    = '0;
        for (int s = 1; s < NUM_ST; s++) begin
            side_next[s] = side_reg[s-1];
        end
        side_next[ST_DEC].zneg = dec_zneg;
        side_next[ST_DEC].big  = |a_mag[gau_pkg::Z_W-1:FB+NW];
        side_next[ST_DEC].n    = a_mag[FB+NW-1:FB];
    end

    // Taylor terms of exp(-f): product, reciprocal multiply, correction
    for (genvar gi = 0; gi < T; gi++) begin : g_tay
        localparam logic [3:0] K = 4'(gi + 1);
        localparam bit PREV_SUB = (gi % 2) == 1;

        logic [30:0]        term_in;
        logic signed [31:0] sum_in;
        logic [QW-1:0]      f30_in;
        logic [60:0]        q_prod;
        logic [61:0]        m_prod;
        logic [QW-1:0]      r_low;

        if (gi == 0) begin : g_first
            assign term_in = gau_pkg::ONE_Q30;
            assign sum_in  = $signed(32'(gau_pkg::ONE_Q30));
            assign f30_in  = dec_f30_reg;
        end else begin : g_rest
            assign term_in = tc_term_reg[gi-1];
            assign f30_in  = tc_f30_reg[gi-1];
            if (PREV_SUB) begin : g_sub
                assign sum_in = tc_sum_reg[gi-1] - $signed(32'(tc_term_reg[gi-1]));
            end else begin : g_add
                assign sum_in = tc_sum_reg[gi-1] + $signed(32'(tc_term_reg[gi-1]));
            end
        end

        always_comb begin
            q_prod          = 61'(term_in) * 61'(f30_in);
            ta_q_next[gi]   = q_prod[59:30];
            ta_sum_next[gi] = sum_in;
            ta_f30_next[gi] = f30_in;

            m_prod          = 62'(ta_q_reg[gi]) * 62'(gau_pkg::RECIP_Q31[gi]);
            tb_q_next[gi]   = ta_q_reg[gi];
            tb_qh_next[gi]  = m_prod[60:31];
            tb_sum_next[gi] = ta_sum_reg[gi];
            tb_f30_next[gi] = ta_f30_reg[gi];

            r_low            = tb_q_reg[gi] - tb_qh_reg[gi] * QW'(K);
            tc_term_next[gi] = 31'(tb_qh_reg[gi]) + 31'(r_low >= QW'(K));
            tc_sum_next[gi]  = tb_sum_reg[gi];
            tc_f30_next[gi]  = tb_f30_reg[gi];
        end
    end

    // Add the last term and floor the sum at zero
    always_comb begin
        if (LAST_SUB) begin
            sum_fin = tc_sum_reg[T-1] - $signed(32'(tc_term_reg[T-1]));
        end else begin
            sum_fin = tc_sum_reg[T-1] + $signed(32'(tc_term_reg[T-1]));
        end
        acc_next = (sum_fin < 0) ? '0 : 31'(sum_fin);
    end

    // Multiply by exp(-1) once per unit of the integer part
    for (genvar gj = 0; gj < E; gj++) begin : g_exp
        logic [30:0] in_val;
        logic [59:0] e_prod;

        if (gj == 0) begin : g_first
            assign in_val = acc_reg;
        end else begin : g_rest
            assign in_val = ex_reg[gj-1];
        end

        always_comb begin
            e_prod = 60'(in_val) * 60'(gau_pkg::EXP_M1_Q30);
            if (side_reg[ST_EXP+gj-1].n > NW'(gj)) begin
                ex_next[gj] = {1'b0, e_prod[59:30]};
            end else begin
                ex_next[gj] = in_val;
            end
        end
    end

    // Form the divisor 1 + exp(-|z|), dropping exp for large |z|
    always_comb begin
        e_sel     = side_reg[ST_DIVD-1].big ? '0 : ex_reg[E-1];
        divd_next = 32'(gau_pkg::ONE_Q30) + 32'(e_sel);
    end

    // Restoring division of 2^60, one quotient bit per stage
    for (genvar gk = 0; gk < DV; gk++) begin : g_div
        logic [31:0] r_sh;
        logic [31:0] d_in;
        logic [30:0] q_in;
        logic        ge;

        if (gk == 0) begin : g_first
            assign r_sh = 32'(gau_pkg::ONE_Q30);
            assign d_in = divd_reg;
            assign q_in = '0;
        end else begin : g_rest
            assign r_sh = {dv_r_reg[gk-1][30:0], 1'b0};
            assign d_in = dv_d_reg[gk-1];
            assign q_in = dv_q_reg[gk-1];
        end

        always_comb begin
            ge            = r_sh >= d_in;
            dv_r_next[gk] = ge ? (r_sh - d_in) : r_sh;
            dv_d_next[gk] = d_in;
            dv_q_next[gk] = {q_in[29:0], ge};
        end
    end

    // Mirror the sigmoid for negative z, multiply, round and saturate
    always_comb begin
        if (side_reg[ST_SEL-1].zneg) begin
            sel_s_next = gau_pkg::ONE_Q30 - dv_q_reg[DV-1];
        end else begin
            sel_s_next = dv_q_reg[DV-1];
        end
        mul_p_next = P_W'($signed(side_reg[ST_MUL-1].x)) * P_W'($signed({1'b0, sel_s_reg}));
        y_rnd      = mul_p_reg + ROUND_HALF;
        y_wide     = Y_W'(y_rnd >>> 30);
        if (y_wide > Y_MAX) begin
            y_sat = Y_MAX[DATA_WIDTH-1:0];
        end else if (y_wide < Y_MIN) begin
            y_sat = Y_MIN[DATA_WIDTH-1:0];
        end else begin
            y_sat = y_wide[DATA_WIDTH-1:0];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[NUM_ST-2:0], sample.valid};
        end
    end

    // Advance pipeline data
    always_ff @(posedge clk) begin
        if (adv) begin
            side_reg     <= side_next;
            xc0_reg      <= xc_next;
            xc1_reg      <= xc0_reg;
            xc2_reg      <= xc1_reg;
            sq_reg       <= sq_next;
            cu_reg       <= cu_next;
            u_reg        <= u_next;
            z_reg        <= z_next;
            dec_f30_reg  <= dec_f30_next;
            ta_q_reg     <= ta_q_next;
            ta_sum_reg   <= ta_sum_next;
            ta_f30_reg   <= ta_f30_next;
            tb_q_reg     <= tb_q_next;
            tb_qh_reg    <= tb_qh_next;
            tb_sum_reg   <= tb_sum_next;
            tb_f30_reg   <= tb_f30_next;
            tc_term_reg  <= tc_term_next;
            tc_sum_reg   <= tc_sum_next;
            tc_f30_reg   <= tc_f30_next;
            acc_reg      <= acc_next;
            ex_reg       <= ex_next;
            divd_reg     <= divd_next;
            dv_r_reg     <= dv_r_next;
            dv_d_reg     <= dv_d_next;
            dv_q_reg     <= dv_q_next;
            sel_s_reg    <= sel_s_next;
            mul_p_reg    <= mul_p_next;
        end
    end

    // Steer the pipeline head into the output register or the skid
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_y_next      = out_y_reg;
        skid_valid_next = skid_valid_reg;
        skid_y_next     = skid_y_reg;
        if (skid_valid_reg) begin
            if (result.ready) begin
                out_y_next      = skid_y_reg;
                skid_valid_next = 1'b0;
            end
        end else begin
            if (out_valid_reg && result.ready) begin
                out_valid_next = 1'b0;
            end
            if (valid_reg[NUM_ST-1]) begin
                if (out_valid_reg && !result.ready) begin
                    skid_valid_next = 1'b1;
                    skid_y_next     = y_sat;
                end else begin
                    out_valid_next = 1'b1;
                    out_y_next     = y_sat;
                end
            end
        end
    end

    // Hold output and skid flags
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold output and skid data
    always_ff @(posedge clk) begin
        out_y_reg  <= out_y_next;
        skid_y_reg <= skid_y_next;
    end

    // The skid only fills behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    // A head beat arriving at a stalled output lands in the skid
    a_head_caught: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NUM_ST-1] && !skid_valid_reg && out_valid_reg && !result.ready)
        |=> skid_valid_reg)
        else $error("pipeline head beat was not caught by the skid");

    // The skid drains as soon as the output beat is taken
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && result.ready) |=> !skid_valid_reg)
        else $error("skid did not drain after the output beat moved");

    // Large |z| gives a sigmoid of exactly one from the divider
    a_big_is_one: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ST_SEL-1] && side_reg[ST_SEL-1].big)
        |-> (dv_q_reg[DV-1] == gau_pkg::ONE_Q30))
        else $error("divider quotient is not one for a large argument");

    // GELU results never go below -0.25 (-1024 in Q.12)
    a_gelu_floor: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (int'(result.y_out) >= GELU_FLOOR_Q12))
        else $error("result below the GELU minimum");

endmodule
